@@ rtl/awm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package awm_pkg;

    // letter code width and alphabet size, fixed by the letter field
    localparam int CODE_W   = 5;
    localparam int ALPHABET = 26;

    typedef logic [CODE_W-1:0] code_t;

    // one input request: mode 0 = pattern letter, 1 = text letter
    typedef struct packed {
        logic  mode;
        code_t char_code;
        logic  last;
    } awm_in_t;

    // one result, given for every text letter
    typedef struct packed {
        logic window_match;
        logic found;
        logic window_full;
        logic pattern_overflow;
        logic end_of_text;
    } awm_out_t;

    // control broadcast to every letter cell
    typedef struct packed {
        logic  clr_pattern;
        logic  clr_window;
        logic  pat_add;
        logic  win_add;
        logic  win_rem;
        code_t add_code;
        code_t rem_code;
    } awm_cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/awm_letter_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module awm_letter_cell
    import awm_pkg::*;
#(
    parameter int    HW    = 9,
    parameter code_t INDEX = '0
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire awm_cell_ctl_t ctl,
    output logic               agree
);

    logic [HW-1:0] pat_reg;
    logic [HW-1:0] pat_next;
    logic [HW-1:0] win_reg;
    logic [HW-1:0] win_next;
    logic [HW-1:0] pat_base;
    logic [HW-1:0] win_base;
    logic          inc;
    logic          dec;

    always_comb
    begin
        pat_base = ctl.clr_pattern ? '0 : pat_reg;
        win_base = ctl.clr_window ? '0 : win_reg;
        inc      = ctl.win_add && (ctl.add_code == INDEX);
        dec      = ctl.win_rem && (ctl.rem_code == INDEX);

        pat_next = pat_base;
        if (ctl.pat_add && (ctl.add_code == INDEX))
        begin
            pat_next = pat_base + HW'(1);
        end

        // letter entering and leaving together cancels out
        win_next = win_base;
        if (inc && !dec)
        begin
            win_next = win_base + HW'(1);
        end
        else if (dec && !inc)
        begin
            win_next = win_base - HW'(1);
        end
    end

    // agreement on the updated counts
    assign agree = (win_next == pat_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg <= '0;
            win_reg <= '0;
        end
        else
        begin
            pat_reg <= pat_next;
            win_reg <= win_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/awm_text_ring.sv @@
`timescale 1ns / 1ps
`default_nettype none

module awm_text_ring
    import awm_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire code_t         wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output code_t              rd_data
);

    code_t mem [DEPTH];
    code_t rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read ahead of use, forwarding a write to the same slot
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_reg <= wr_data;
        end
        else
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_reg;

endmodule

`default_nettype wire

@@ rtl/awm_out_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none

module awm_out_buf
    import awm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire awm_out_t push_data,
    output logic          busy,
    output logic          result_valid,
    input  wire logic     result_stall,
    output awm_out_t      result
);

    logic     main_valid_reg;
    awm_out_t main_reg;
    logic     skid_valid_reg;
    awm_out_t skid_reg;
    logic     main_free;

    assign main_free = !main_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_free)
        begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

    assign busy         = skid_valid_reg;
    assign result_valid = main_valid_reg;
    assign result       = main_reg;

endmodule

`default_nettype wire

@@ rtl/anagram_window_matcher_core.sv @@
// the result of a text letter is registered in the main result register, or in the skid entry while that is held
// throughput: one letter request per cycle while letter_stall is low; pattern letters give no result
// a two-entry result buffer lets letters flow while one result waits downstream
// window counts and match check are updated by per-letter cells in the same cycle
// reset (rst_n, async, active low) clears pattern, window, counters and flags
`timescale 1ns / 1ps
`default_nettype none

module anagram_window_matcher_core
    import awm_pkg::*;
#(
    parameter int MAX_PATTERN = 256
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     letter_valid,
    output logic          letter_stall,
    input  wire awm_in_t  letter,
    output logic          result_valid,
    input  wire logic     result_stall,
    output awm_out_t      result
);

    // count width holds MAX_PATTERN itself; ring address needs at least one bit
    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // search state
    logic [LW-1:0] pattern_len_reg;
    logic [LW-1:0] pattern_len_next;
    logic [LW-1:0] text_seen_reg;
    logic [LW-1:0] text_seen_next;
    logic [AW-1:0] ring_pos_reg;
    logic [AW-1:0] ring_pos_next;
    logic          found_reg;
    logic          found_next;
    logic          overflow_reg;
    logic          overflow_next;
    logic          ended_reg;
    logic          ended_next;

    // request decode
    logic          fire;
    logic          is_text;
    logic          in_alpha;
    logic          clr_search;
    logic          clr_text;

    // state after any clear that this request causes
    logic [LW-1:0] plen_base;
    logic [LW-1:0] seen_base;
    logic [AW-1:0] pos_base;
    logic          found_base;
    logic          overflow_base;

    logic          pat_ok;
    logic          pat_add;
    logic          step;
    logic          full_before;
    logic          full;
    logic          match;
    logic [LW-1:0] pos_inc;

    code_t         old_code;
    awm_cell_ctl_t cell_ctl;
    logic [ALPHABET-1:0] agree_vec;
    logic          all_agree;

    logic          buf_busy;
    awm_out_t      res_data;

    assign letter_stall = buf_busy;
    assign fire         = letter_valid && !buf_busy;
    assign is_text      = letter.mode;
    assign in_alpha     = (letter.char_code < CODE_W'(ALPHABET));

    always_comb
    begin
        // a pattern letter after an ended text, a counted text letter or a match starts a fresh search
        clr_search = fire && !is_text && (ended_reg || (text_seen_reg != '0) || found_reg);
        // a text letter after a finished text keeps the pattern, drops the window
        clr_text   = clr_search || (fire && is_text && ended_reg);

        plen_base     = clr_search ? '0 : pattern_len_reg;
        overflow_base = clr_search ? 1'b0 : overflow_reg;
        seen_base     = clr_text ? '0 : text_seen_reg;
        pos_base      = clr_text ? '0 : ring_pos_reg;
        found_base    = clr_text ? 1'b0 : found_reg;

        // pattern letters beyond the limit are dropped and flagged
        pat_ok        = fire && !is_text && in_alpha;
        pat_add       = pat_ok && (plen_base < LW'(MAX_PATTERN));
        overflow_next = overflow_base || (pat_ok && !pat_add);
        pattern_len_next = pat_add ? (plen_base + LW'(1)) : plen_base;

        // a text letter enters the window only if valid and a pattern exists
        step        = fire && is_text && in_alpha && (plen_base != '0);
        full_before = (seen_base >= plen_base);

        text_seen_next = (step && !full_before) ? (seen_base + LW'(1)) : seen_base;

        // ring position wraps at the pattern length
        pos_inc = LW'(pos_base) + LW'(1);
        if (step)
        begin
            ring_pos_next = (pos_inc == plen_base) ? '0 : AW'(pos_inc);
        end
        else
        begin
            ring_pos_next = pos_base;
        end

        full  = (text_seen_next >= plen_base);
        match = full && all_agree;

        found_next = found_base || (fire && is_text && match);

        if (fire && is_text)
        begin
            ended_next = letter.last;
        end
        else if (clr_search)
        begin
            ended_next = 1'b0;
        end
        else
        begin
            ended_next = ended_reg;
        end
    end

    // broadcast to the letter cells: leaving letter is the prefetched ring slot
    always_comb
    begin
        cell_ctl.clr_pattern = clr_search;
        cell_ctl.clr_window  = clr_text;
        cell_ctl.pat_add     = pat_add;
        cell_ctl.win_add     = step;
        cell_ctl.win_rem     = step && full_before && (old_code < CODE_W'(ALPHABET));
        cell_ctl.add_code    = letter.char_code;
        cell_ctl.rem_code    = old_code;
    end

    // one counter pair per letter of the alphabet
    for (genvar k = 0; k < ALPHABET; k++)
    begin : g_cell
        awm_letter_cell #(
            .HW    (LW),
            .INDEX (CODE_W'(k))
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (cell_ctl),
            .agree (agree_vec[k])
        );
    end

    // window is a permutation when every letter count agrees
    assign all_agree = &agree_vec;

    // ring of recent text letters, read one request ahead at the next position
    awm_text_ring #(
        .DEPTH (MAX_PATTERN),
        .AW    (AW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (step),
        .wr_addr (pos_base),
        .wr_data (letter.char_code),
        .rd_addr (ring_pos_next),
        .rd_data (old_code)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_len_reg <= '0;
            text_seen_reg   <= '0;
            ring_pos_reg    <= '0;
            found_reg       <= 1'b0;
            overflow_reg    <= 1'b0;
            ended_reg       <= 1'b0;
        end
        else if (fire)
        begin
            pattern_len_reg <= pattern_len_next;
            text_seen_reg   <= text_seen_next;
            ring_pos_reg    <= ring_pos_next;
            found_reg       <= found_next;
            overflow_reg    <= overflow_next;
            ended_reg       <= ended_next;
        end
    end

    always_comb
    begin
        res_data.window_match     = match;
        res_data.found            = found_next;
        res_data.window_full      = full;
        res_data.pattern_overflow = overflow_base;
        res_data.end_of_text      = letter.last;
    end

    // result register with skid entry
    awm_out_buf u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (fire && is_text),
        .push_data    (res_data),
        .busy         (buf_busy),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

@@ sim/anagram_window_matcher_core_tb.sv @@
`timescale 1ns / 1ps

module anagram_window_matcher_core_tb;
    import awm_pkg::*;

    // ring depth and longest kept pattern, same as the block's default
    localparam int MAX_PAT        = 256;
    // random requests outside the one long search
    localparam int RAND_ITEMS     = 200;
    // cycles with no request and no result accepted before the run is called hung
    localparam int WATCHDOG_LIMIT = 4000;
    // quiet cycles after the last result
    localparam int TAIL_CYCLES    = 10;

    localparam logic MODE_PATTERN = 1'b0;
    localparam logic MODE_TEXT    = 1'b1;
    localparam int   CODE_MAX     = 31;

    logic     clk;
    logic     rst_n;
    logic     letter_valid;
    logic     letter_stall;
    awm_in_t  letter;
    logic     result_valid;
    logic     result_stall;
    awm_out_t result;

    anagram_window_matcher_core #(
        .MAX_PATTERN (MAX_PAT)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .letter_valid (letter_valid),
        .letter_stall (letter_stall),
        .letter       (letter),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // directed rows: want is {window_match, found, window_full, pattern_overflow, end_of_text}
    // and is only used where typed is set, the rest go through the predictor
    typedef struct {
        bit       mode;
        int       code;
        bit       last;
        bit       typed;
        bit [4:0] want;
    } dir_row_t;

    dir_row_t dir_tab [23] = '{
        // empty pattern right after reset: every window matches
        '{MODE_TEXT,     0, 1'b0, 1'b1, 5'b11100},
        // letter outside the alphabet still reports, and ends the text
        '{MODE_TEXT,    31, 1'b1, 1'b1, 5'b11101},
        // pattern after an ended text starts a new search: pattern a b z
        '{MODE_PATTERN,  0, 1'b0, 1'b0, 5'b00000},
        '{MODE_PATTERN,  1, 1'b0, 1'b0, 5'b00000},
        // out of alphabet pattern letter is dropped
        '{MODE_PATTERN, 31, 1'b0, 1'b0, 5'b00000},
        '{MODE_PATTERN, 25, 1'b1, 1'b0, 5'b00000},
        // window filling up, the out of alphabet letter does not count
        '{MODE_TEXT,    25, 1'b0, 1'b1, 5'b00000},
        '{MODE_TEXT,     1, 1'b0, 1'b1, 5'b00000},
        '{MODE_TEXT,    30, 1'b0, 1'b1, 5'b00000},
        // z b a is a permutation of a b z
        '{MODE_TEXT,     0, 1'b0, 1'b1, 5'b11100},
        // z leaves, window b a a, found stays set
        '{MODE_TEXT,     0, 1'b0, 1'b1, 5'b01100},
        '{MODE_TEXT,    26, 1'b1, 1'b1, 5'b01101},
        // new text keeps the pattern but clears window and found
        '{MODE_TEXT,     1, 1'b0, 1'b1, 5'b00000},
        '{MODE_TEXT,    16, 1'b0, 1'b0, 5'b00000},
        '{MODE_TEXT,    25, 1'b0, 1'b0, 5'b00000},
        // pattern in the middle of a text restarts the search
        '{MODE_PATTERN, 16, 1'b0, 1'b0, 5'b00000},
        '{MODE_PATTERN, 15, 1'b1, 1'b0, 5'b00000},
        '{MODE_TEXT,    15, 1'b0, 1'b0, 5'b00000},
        '{MODE_TEXT,    16, 1'b0, 1'b0, 5'b00000},
        '{MODE_TEXT,     8, 1'b1, 1'b0, 5'b00000},
        // a pattern of only dropped letters leaves the pattern empty
        '{MODE_PATTERN, 28, 1'b1, 1'b0, 5'b00000},
        '{MODE_TEXT,     8, 1'b0, 1'b1, 5'b11100},
        '{MODE_TEXT,    27, 1'b1, 1'b0, 5'b00000}
    };

    string field_name [5] = '{"window_match", "found", "window_full",
                              "pattern_overflow", "end_of_text"};

    // predictor state, widths as in the block
    logic [8:0] pat_count [ALPHABET];
    logic [8:0] win_count [ALPHABET];
    logic [4:0] agree;
    logic [8:0] pat_len;
    code_t      ring [MAX_PAT];
    logic [7:0] ring_pos;
    logic [8:0] text_seen;
    bit         found_q;
    bit         ovf_q;
    bit         text_done;

    // verdicts still owed by the block, oldest first
    awm_out_t   verdict_q [$];

    int n_fail;
    int n_sent;
    int n_checked;
    int n_match;
    int n_ovf;
    int burst_left;
    int idle_cycles;
    int big_items;
    logic [7:0] stall_cyc;

    // clock, 8 ns period
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // --------------------------------------------------------------------
    // predictor
    // --------------------------------------------------------------------

    // drop the text side: window, ring, found, keep the pattern
    function automatic void clear_text_state();
        agree = '0;
        for (int k = 0; k < ALPHABET; k++)
        begin
            win_count[k] = '0;
            if (pat_count[k] == 0)
                agree++;
        end
        for (int k = 0; k < MAX_PAT; k++)
            ring[k] = '0;
        ring_pos  = '0;
        text_seen = '0;
        found_q   = 1'b0;
        text_done = 1'b0;
    endfunction

    // new search: pattern goes too
    function automatic void clear_search_state();
        for (int k = 0; k < ALPHABET; k++)
            pat_count[k] = '0;
        pat_len = '0;
        ovf_q   = 1'b0;
        clear_text_state();
    endfunction

    // move one window count, keeping the number of agreeing letters
    function automatic void shift_window_count(code_t c, bit up);
        if (win_count[c] == pat_count[c])
            agree--;
        if (up)
            win_count[c]++;
        else
            win_count[c]--;
        if (win_count[c] == pat_count[c])
            agree++;
    endfunction

    // one request through the search; returns 1 when it yields a verdict
    function automatic bit predict_verdict(input awm_in_t req, output awm_out_t res);
        code_t c;
        code_t gone;
        bit    full;
        bit    hit;
        c   = req.char_code;
        res = '0;
        if (req.mode == MODE_PATTERN)
        begin
            if (text_done || text_seen != 0 || found_q)
                clear_search_state();
            if (c >= ALPHABET)
                return 1'b0;
            if (pat_len >= MAX_PAT)
            begin
                ovf_q = 1'b1;
                return 1'b0;
            end
            // window is empty while the pattern grows
            if (pat_count[c] == 0)
                agree--;
            pat_count[c]++;
            pat_len++;
            return 1'b0;
        end
        if (text_done)
            clear_text_state();
        if (c < ALPHABET && pat_len != 0)
        begin
            if (text_seen >= pat_len)
            begin
                // oldest letter leaves the window
                gone = ring[ring_pos];
                if (gone < ALPHABET)
                    shift_window_count(gone, 1'b0);
            end
            else
                text_seen++;
            shift_window_count(c, 1'b1);
            ring[ring_pos] = c;
            ring_pos = 8'((int'(ring_pos) + 1) % int'(pat_len));
        end
        full = (text_seen >= pat_len);
        hit  = full && (agree == ALPHABET);
        if (hit)
            found_q = 1'b1;
        text_done = req.last;
        res.window_match     = hit;
        res.found            = found_q;
        res.window_full      = full;
        res.pattern_overflow = ovf_q;
        res.end_of_text      = req.last;
        return 1'b1;
    endfunction

    function automatic awm_in_t letter_req(logic mode, code_t code, logic last);
        awm_in_t r;
        r.mode      = mode;
        r.char_code = code;
        r.last      = last;
        return r;
    endfunction

    // --------------------------------------------------------------------
    // request side: bursts of random length, random gaps between them
    // --------------------------------------------------------------------

    task automatic send_letter(input awm_in_t req, input bit typed, input awm_out_t typed_res);
        awm_out_t res;
        int       gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(30, 1);
            // a quarter of the bursts follow straight on
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
            if (gap != 0)
            begin
                letter_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        letter       <= req;
        letter_valid <= 1'b1;
        @(posedge clk);
        while (letter_stall)
            @(posedge clk);
        n_sent++;
        if (predict_verdict(req, res))
        begin
            if (typed)
                res = typed_res;
            if (res.window_match)
                n_match++;
            if (res.pattern_overflow)
                n_ovf++;
            verdict_q.push_back(res);
        end
    endtask

    // hold off requests until every owed verdict has come back
    task automatic drain_verdicts();
        letter_valid <= 1'b0;
        burst_left = 0;
        while (verdict_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random(logic mode, code_t code, logic last);
        send_letter(letter_req(mode, code, last), 1'b0, '0);
    endtask

    // one search: pattern from a range of span letters, then texts built around
    // a shuffled copy of the pattern so that matches actually happen; the long
    // form pushes the pattern past the ring and wraps the ring once
    task automatic run_search(input int plen, input int span, input bit big);
        code_t kept [$];
        code_t txt  [$];
        code_t perm [$];
        code_t c;
        code_t tmp;
        int    base;
        int    n_texts;
        int    stop_at;
        int    j;
        bit    cut;
        base = $urandom_range(ALPHABET - span, 0);
        for (int i = 0; i < plen; i++)
        begin
            if (!big && $urandom_range(11, 0) == 0)
                send_random(MODE_PATTERN, code_t'($urandom_range(CODE_MAX, ALPHABET)), 1'b0);
            c = code_t'(base + $urandom_range(span - 1, 0));
            // last on a pattern letter means nothing, so scatter it
            send_random(MODE_PATTERN, c,
                        (i == plen - 1) ? 1'($urandom_range(1, 0))
                                        : 1'($urandom_range(15, 0) == 0));
            if (kept.size() < MAX_PAT)
                kept.push_back(c);
        end
        n_texts = big ? 1 : $urandom_range(3, 1);
        for (int t = 0; t < n_texts; t++)
        begin
            txt.delete();
            perm = kept;
            for (int i = perm.size() - 1; i > 0; i--)
            begin
                j       = $urandom_range(i, 0);
                tmp     = perm[i];
                perm[i] = perm[j];
                perm[j] = tmp;
            end
            repeat (big ? $urandom_range(5, 2) : $urandom_range(4, 0))
                txt.push_back(code_t'(base + $urandom_range(span - 1, 0)));
            foreach (perm[i])
                txt.push_back(perm[i]);
            repeat (big ? $urandom_range(6, 3) : $urandom_range(4, 0))
                txt.push_back(code_t'(base + $urandom_range(span - 1, 0)));
            // sometimes the final text breaks off and the next pattern cuts in
            cut     = !big && (t == n_texts - 1) && ($urandom_range(4, 0) == 0);
            stop_at = cut ? $urandom_range(txt.size(), 1) : txt.size();
            for (int k = 0; k < stop_at; k++)
            begin
                c = txt[k];
                if (!big && $urandom_range(15, 0) == 0)
                    c = code_t'($urandom_range(CODE_MAX, ALPHABET));
                send_random(MODE_TEXT, c, !cut && (k == stop_at - 1));
            end
        end
    endtask

    // --------------------------------------------------------------------
    // result side: stall pattern taken from the top bits of a free-running counter,
    // none, light random, periodic, heavy random
    // --------------------------------------------------------------------

    always @(posedge clk)
    begin
        stall_cyc <= stall_cyc + 8'd1;
        case (stall_cyc[7:6])
            2'd0:    result_stall <= 1'b0;
            2'd1:    result_stall <= ($urandom_range(9, 0) < 3);
            2'd2:    result_stall <= (stall_cyc[2:0] < 3'd3);
            default: result_stall <= ($urandom_range(9, 0) < 7);
        endcase
    end

    // every accepted result against the oldest owed verdict
    always @(posedge clk)
    begin
        awm_out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("result %b with no verdict owed", result);
                n_fail++;
            end
            else
            begin
                want = verdict_q.pop_front();
                n_checked++;
                for (int i = 0; i < 5; i++)
                begin
                    if (result[4-i] !== want[4-i])
                    begin
                        $error("%s: expected %0b, got %0b", field_name[i], want[4-i],
                               result[4-i]);
                        n_fail++;
                    end
                end
            end
        end
    end

    // watchdog on cycles where neither side moves
    always @(posedge clk)
    begin
        if (!rst_n || (letter_valid && !letter_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: nothing accepted for %0d cycles, %0d verdicts owed",
                     WATCHDOG_LIMIT, verdict_q.size());
            $display("Test completed with failures");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // --------------------------------------------------------------------
    // main sequence
    // --------------------------------------------------------------------

    initial
    begin
        awm_in_t req;
        int      pick;
        int      mark;
        bit      big_done;
        rst_n        = 1'b0;
        letter_valid = 1'b0;
        letter       = '0;
        result_stall = 1'b0;
        stall_cyc    = '0;
        idle_cycles  = 0;
        n_fail       = 0;
        n_sent       = 0;
        n_checked    = 0;
        n_match      = 0;
        n_ovf        = 0;
        burst_left   = 0;
        big_items    = 0;
        big_done     = 1'b0;
        clear_search_state();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows
        foreach (dir_tab[i])
        begin
            req = letter_req(dir_tab[i].mode, code_t'(dir_tab[i].code), dir_tab[i].last);
            send_letter(req, dir_tab[i].typed, awm_out_t'(dir_tab[i].want));
        end
        drain_verdicts();

        // random part; the single long search does not count toward the budget
        while (n_sent - big_items < $size(dir_tab) + RAND_ITEMS)
        begin
            if (!big_done && n_sent - big_items >= $size(dir_tab) + RAND_ITEMS / 2)
            begin
                mark = n_sent;
                run_search($urandom_range(MAX_PAT + 6, MAX_PAT + 2), ALPHABET, 1'b1);
                big_items = n_sent - mark;
                big_done  = 1'b1;
            end
            pick = $urandom_range(99, 0);
            if (pick < 75)
            begin
                // mostly short patterns, now and then a longer one
                run_search(($urandom_range(9, 0) == 0) ? $urandom_range(24, 7)
                                                       : $urandom_range(6, 1),
                           $urandom_range(6, 2), 1'b0);
            end
            else if (pick < 85)
            begin
                // dropped pattern letter, then a short text of any codes
                send_random(MODE_PATTERN, code_t'($urandom_range(CODE_MAX, ALPHABET)),
                            1'($urandom_range(1, 0)));
                mark = $urandom_range(6, 1);
                for (int k = 0; k < mark; k++)
                    send_random(MODE_TEXT, code_t'($urandom_range(CODE_MAX, 0)),
                                k == mark - 1);
            end
            else
            begin
                // unstructured requests
                repeat ($urandom_range(10, 1))
                    send_random(1'($urandom_range(1, 0)),
                                code_t'($urandom_range(CODE_MAX, 0)),
                                1'($urandom_range(3, 0) == 0));
            end
            // sender waits for the block to empty out now and then
            if ($urandom_range(7, 0) == 0)
                drain_verdicts();
        end

        drain_verdicts();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d letter requests sent, %0d verdicts checked, %0d of them matches",
                 n_sent, n_checked, n_match);
        $display("long search of %0d requests wrapped the ring, %0d verdicts flagged overflow",
                 big_items, n_ovf);
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
